>>> rtl/xalu_pkg.sv
`timescale 1ns / 1ps

package xalu_pkg;

	typedef enum logic [3:0] {
		CMD_ADD = 4'd0,
		CMD_ADC = 4'd1,
		CMD_SUB = 4'd2,
		CMD_SBB = 4'd3,
		CMD_AND = 4'd4,
		CMD_OR  = 4'd5,
		CMD_XOR = 4'd6,
		CMD_INC = 4'd7,
		CMD_DEC = 4'd8,
		CMD_NOT = 4'd9,
		CMD_ROL = 4'd10,
		CMD_ROR = 4'd11,
		CMD_RCR = 4'd12,
		CMD_SHL = 4'd13,
		CMD_SHR = 4'd14,
		CMD_MUL = 4'd15
	} cmd_t;

	// flag positions in the written mask
	localparam int FLG_C = 0;
	localparam int FLG_P = 1;
	localparam int FLG_A = 2;
	localparam int FLG_Z = 3;
	localparam int FLG_S = 4;
	localparam int FLG_O = 5;

	localparam logic [5:0] FW_C = 6'h01;
	localparam logic [5:0] FW_P = 6'h02;
	localparam logic [5:0] FW_A = 6'h04;
	localparam logic [5:0] FW_Z = 6'h08;
	localparam logic [5:0] FW_S = 6'h10;
	localparam logic [5:0] FW_O = 6'h20;

	localparam int S_TDATA_W = 48;
	localparam int M_TDATA_W = 48;

	typedef struct packed {
		cmd_t        cmd;
		logic        wide;
		logic [15:0] opa;
		logic [15:0] opb;
		logic        cin;
		logic [4:0]  cnt;
	} alu_req_t;

	typedef struct packed {
		logic [15:0] result;
		logic [15:0] result_high;
		logic        carry;
		logic        parity;
		logic        aux_carry;
		logic        zero;
		logic        sign;
		logic        overflow;
		logic [5:0]  written;
	} alu_rsp_t;

	typedef struct packed {
		logic [15:0] res;
		logic        c;
		logic        o;
	} shift_rsp_t;

endpackage

>>> rtl/xalu_shift.sv
`timescale 1ns / 1ps

module xalu_shift (
	input  xalu_pkg::cmd_t     cmd,
	input  logic               wide,
	input  logic [15:0]        opa,
	input  logic               cin,
	input  logic [4:0]         cnt,
	output xalu_pkg::shift_rsp_t sh
);

	logic [2:0]  n8;
	logic [3:0]  n16;
	logic [15:0] d8;
	logic [31:0] d16;
	logic [15:0] rl8, rr8;
	logic [31:0] rl16, rr16;
	logic [4:0]  nrc8, nrc16;
	logic [17:0] dv8, y8;
	logic [33:0] dv16, y16;
	logic [47:0] shl_ext;
	logic [16:0] shr_ext;
	logic [15:0] x;
	logic        c;
	logic        x_top, x_next;

	assign n8  = cnt[2:0];
	assign n16 = cnt[3:0];
	assign d8  = {opa[7:0], opa[7:0]};
	assign d16 = {opa, opa};
	assign rl8  = d8 << n8;
	assign rr8  = d8 >> n8;
	assign rl16 = d16 << n16;
	assign rr16 = d16 >> n16;

	// rotate through carry spans width plus one bits
	always_comb begin
		if (cnt >= 5'd27) begin
			nrc8 = cnt - 5'd27;
		end else if (cnt >= 5'd18) begin
			nrc8 = cnt - 5'd18;
		end else if (cnt >= 5'd9) begin
			nrc8 = cnt - 5'd9;
		end else begin
			nrc8 = cnt;
		end
		nrc16 = (cnt >= 5'd17) ? (cnt - 5'd17) : cnt;
	end

	assign dv8  = {cin, opa[7:0], cin, opa[7:0]};
	assign dv16 = {cin, opa, cin, opa};
	assign y8   = dv8 >> nrc8;
	assign y16  = dv16 >> nrc16;

	assign shl_ext = {32'd0, opa} << cnt;
	assign shr_ext = {opa, 1'b0} >> cnt;

	always_comb begin
		x = opa;
		c = cin;
		unique case (cmd)
			xalu_pkg::CMD_ROL: begin
				x = wide ? rl16[31:16] : {8'd0, rl8[15:8]};
				c = x[0];
			end
			xalu_pkg::CMD_ROR: begin
				x = wide ? rr16[15:0] : {8'd0, rr8[7:0]};
				c = wide ? x[15] : x[7];
			end
			xalu_pkg::CMD_RCR: begin
				x = wide ? y16[15:0] : {8'd0, y8[7:0]};
				c = wide ? y16[16] : y8[8];
			end
			xalu_pkg::CMD_SHL: begin
				x = wide ? shl_ext[15:0] : {8'd0, shl_ext[7:0]};
				c = wide ? shl_ext[16] : shl_ext[8];
			end
			xalu_pkg::CMD_SHR: begin
				x = shr_ext[16:1];
				c = shr_ext[0];
			end
			default: begin
				x = opa;
				c = cin;
			end
		endcase
	end

	assign x_top  = wide ? x[15] : x[7];
	assign x_next = wide ? x[14] : x[6];

	always_comb begin
		sh.res = x;
		sh.c   = c;
		case (cmd) inside
			xalu_pkg::CMD_ROL, xalu_pkg::CMD_SHL: sh.o = x_top ^ c;
			xalu_pkg::CMD_ROR, xalu_pkg::CMD_RCR: sh.o = x_top ^ x_next;
			xalu_pkg::CMD_SHR:                    sh.o = wide ? opa[15] : opa[7];
			default:                              sh.o = 1'b0;
		endcase
	end

endmodule

>>> rtl/xalu_core.sv
`timescale 1ns / 1ps

module xalu_core (
	input  xalu_pkg::alu_req_t req,
	output xalu_pkg::alu_rsp_t rsp
);

	logic [15:0] mask, msb, amask;
	logic [15:0] a, b, bb;
	logic        is_sub, cin_add;
	logic [16:0] sum;
	logic [15:0] add_r;
	logic        add_c, add_aux, add_o;
	logic [15:0] inc_r, dec_r;
	logic [31:0] prod;
	logic [15:0] mul_hi;
	xalu_pkg::shift_rsp_t sh;

	logic [15:0] res, hi;
	logic        c, aux, o, z, s, p;
	logic [5:0]  fw;

	assign mask  = req.wide ? 16'hFFFF : 16'h00FF;
	assign msb   = req.wide ? 16'h8000 : 16'h0080;
	assign amask = req.wide ? 16'h00FF : 16'h000F;
	assign a     = req.opa & mask;
	assign b     = req.opb & mask;

	assign is_sub = (req.cmd == xalu_pkg::CMD_SUB) || (req.cmd == xalu_pkg::CMD_SBB);
	assign bb     = is_sub ? (b ^ mask) : b;

	always_comb begin
		case (req.cmd)
			xalu_pkg::CMD_ADC: cin_add = req.cin;
			xalu_pkg::CMD_SUB: cin_add = 1'b1;
			xalu_pkg::CMD_SBB: cin_add = ~req.cin;
			default:           cin_add = 1'b0;
		endcase
	end

	assign sum     = {1'b0, a} + {1'b0, bb} + {16'd0, cin_add};
	assign add_r   = sum[15:0] & mask;
	assign add_c   = req.wide ? sum[16] : sum[8];
	// carry into bit 4 or bit 8 recovered from the sum bit
	assign add_aux = req.wide ? (a[8] ^ bb[8] ^ sum[8]) : (a[4] ^ bb[4] ^ sum[4]);
	assign add_o   = |((add_r ^ a) & (add_r ^ bb) & msb);

	assign inc_r = (a + 16'd1) & mask;
	assign dec_r = (a - 16'd1) & mask;

	assign prod   = {16'd0, a} * {16'd0, b};
	assign mul_hi = req.wide ? prod[31:16] : {8'd0, prod[15:8]};

	xalu_shift u_shift (
		.cmd  (req.cmd),
		.wide (req.wide),
		.opa  (a),
		.cin  (req.cin),
		.cnt  (req.cnt),
		.sh   (sh)
	);

	always_comb begin
		res = a;
		hi  = 16'd0;
		c   = req.cin;
		aux = 1'b0;
		o   = 1'b0;
		fw  = 6'd0;
		unique case (req.cmd) inside
			xalu_pkg::CMD_ADD, xalu_pkg::CMD_ADC, xalu_pkg::CMD_SUB, xalu_pkg::CMD_SBB: begin
				res = add_r;
				c   = add_c ^ is_sub;
				aux = add_aux ^ is_sub;
				o   = add_o;
				fw  = xalu_pkg::FW_C | xalu_pkg::FW_P | xalu_pkg::FW_A |
				      xalu_pkg::FW_Z | xalu_pkg::FW_S | xalu_pkg::FW_O;
			end
			xalu_pkg::CMD_AND, xalu_pkg::CMD_OR, xalu_pkg::CMD_XOR: begin
				if (req.cmd == xalu_pkg::CMD_AND) begin
					res = a & b;
				end else if (req.cmd == xalu_pkg::CMD_OR) begin
					res = a | b;
				end else begin
					res = a ^ b;
				end
				c  = 1'b0;
				fw = xalu_pkg::FW_C | xalu_pkg::FW_P | xalu_pkg::FW_Z |
				     xalu_pkg::FW_S | xalu_pkg::FW_O;
			end
			xalu_pkg::CMD_INC: begin
				res = inc_r;
				aux = (a & amask) == amask;
				o   = a == (msb - 16'd1);
				fw  = xalu_pkg::FW_P | xalu_pkg::FW_A | xalu_pkg::FW_Z |
				      xalu_pkg::FW_S | xalu_pkg::FW_O;
			end
			xalu_pkg::CMD_DEC: begin
				res = dec_r;
				aux = (a & amask) == 16'd0;
				o   = a == msb;
				fw  = xalu_pkg::FW_P | xalu_pkg::FW_A | xalu_pkg::FW_Z |
				      xalu_pkg::FW_S | xalu_pkg::FW_O;
			end
			xalu_pkg::CMD_NOT: begin
				res = ~a & mask;
			end
			xalu_pkg::CMD_ROL, xalu_pkg::CMD_ROR, xalu_pkg::CMD_RCR: begin
				// zero count leaves operand and flags untouched
				if (req.cnt != 5'd0) begin
					res = sh.res;
					c   = sh.c;
					o   = sh.o;
					fw  = xalu_pkg::FW_C | xalu_pkg::FW_O;
				end
			end
			xalu_pkg::CMD_SHL, xalu_pkg::CMD_SHR: begin
				if (req.cnt != 5'd0) begin
					res = sh.res;
					c   = sh.c;
					o   = sh.o;
					fw  = xalu_pkg::FW_C | xalu_pkg::FW_P | xalu_pkg::FW_Z |
					      xalu_pkg::FW_S | xalu_pkg::FW_O;
				end
			end
			xalu_pkg::CMD_MUL: begin
				res = prod[15:0] & mask;
				hi  = mul_hi;
				c   = mul_hi != 16'd0;
				o   = mul_hi != 16'd0;
				fw  = xalu_pkg::FW_C | xalu_pkg::FW_O;
			end
			default: begin
				res = a;
			end
		endcase
	end

	assign z = res == 16'd0;
	assign s = |(res & msb);
	assign p = ~^res[7:0];

	// drop flags that the operation does not write; carry passes through unmasked
	assign rsp.result      = res;
	assign rsp.result_high = hi;
	assign rsp.carry       = c;
	assign rsp.parity      = p & fw[xalu_pkg::FLG_P];
	assign rsp.aux_carry   = aux & fw[xalu_pkg::FLG_A];
	assign rsp.zero        = z & fw[xalu_pkg::FLG_Z];
	assign rsp.sign        = s & fw[xalu_pkg::FLG_S];
	assign rsp.overflow    = o & fw[xalu_pkg::FLG_O];
	assign rsp.written     = fw;

endmodule

>>> rtl/x86_alu_with_flags_unit.sv
`timescale 1ns / 1ps
// Throughput: one transaction per cycle unless the master side stalls; the input register,
// one combinational pass (adder, barrel shifter and a 16x16 multiplier) and the result
// register set that figure. An empty input register takes a new input transaction while a
// finished result waits. Reset (arst_n low, asynchronous) empties both stages; payload
// registers are not cleared.

module x86_alu_with_flags_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// command[3:0], operand_a[19:4], operand_b[35:20], carry_in[36], shift_count[41:37]
	input  logic [xalu_pkg::S_TDATA_W-1:0] s_axis_tdata,
	// wide
	input  logic        s_axis_tuser,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// result[15:0], result_high[31:16], carry[32], parity[33], aux_carry[34],
	// zero[35], sign[36], overflow[37], flags_written[43:38]
	output logic [xalu_pkg::M_TDATA_W-1:0] m_axis_tdata
);

	xalu_pkg::alu_req_t req_d, req_s1;
	xalu_pkg::alu_rsp_t rsp_c, rsp_s2;
	logic vld_s1, vld_s2;
	logic adv1, adv2;

	assign req_d.cmd  = xalu_pkg::cmd_t'(s_axis_tdata[3:0]);
	assign req_d.wide = s_axis_tuser;
	assign req_d.opa  = s_axis_tdata[19:4];
	assign req_d.opb  = s_axis_tdata[35:20];
	assign req_d.cin  = s_axis_tdata[36];
	assign req_d.cnt  = s_axis_tdata[41:37];

	assign adv2 = !vld_s2 || m_axis_tready;
	assign adv1 = !vld_s1 || adv2;
	assign s_axis_tready = adv1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			if (adv1) begin
				vld_s1 <= s_axis_tvalid;
			end
			if (adv2) begin
				vld_s2 <= vld_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv1 && s_axis_tvalid) begin
			req_s1 <= req_d;
		end
		if (adv2 && vld_s1) begin
			rsp_s2 <= rsp_c;
		end
	end

	xalu_core u_core (
		.req (req_s1),
		.rsp (rsp_c)
	);

	assign m_axis_tvalid = vld_s2;
	assign m_axis_tdata  = {4'd0, rsp_s2.written, rsp_s2.overflow, rsp_s2.sign, rsp_s2.zero,
	                        rsp_s2.aux_carry, rsp_s2.parity, rsp_s2.carry,
	                        rsp_s2.result_high, rsp_s2.result};

`ifndef SYNTHESIS
	// an item held in the input stage behind a stalled result must survive
	a_hold_s1: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 && vld_s2 && !m_axis_tready |=> vld_s1 && $stable(req_s1))
		else $error("input stage lost its transaction under stall");

	a_unwritten_zero: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s2 |-> ((rsp_s2.parity && !rsp_s2.written[xalu_pkg::FLG_P]) ||
		            (rsp_s2.aux_carry && !rsp_s2.written[xalu_pkg::FLG_A]) ||
		            (rsp_s2.zero && !rsp_s2.written[xalu_pkg::FLG_Z]) ||
		            (rsp_s2.sign && !rsp_s2.written[xalu_pkg::FLG_S]) ||
		            (rsp_s2.overflow && !rsp_s2.written[xalu_pkg::FLG_O])) == 1'b0)
		else $error("flag set that the operation does not write");

	a_mul_high: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s2 && (rsp_s2.result_high != 16'd0) |->
		rsp_s2.carry && rsp_s2.overflow && rsp_s2.written[xalu_pkg::FLG_C])
		else $error("nonzero product high half without carry and overflow");
`endif

endmodule
